// ----- rtl/core/i2cmbw_pkg.sv -----
// Package: phase codes, command codes and constants for the I2C master byte writer.
`timescale 1ns / 1ps

package i2cmbw_pkg;

    typedef enum logic [3:0] {
        PH_IDLE        = 4'd0,
        PH_START_FALL  = 4'd1,
        PH_START_WAIT  = 4'd2,
        PH_STOP_RISE   = 4'd3,
        PH_STOP_WAIT   = 4'd4,
        PH_CLK_RISE    = 4'd5,
        PH_CLK_UNIT1   = 4'd6,
        PH_CLK_STRETCH = 4'd7,
        PH_CLK_WAIT3   = 4'd8,
        PH_CLK_WAIT2   = 4'd9,
        PH_BIT_NEXT    = 4'd10
    } phase_t;

    typedef enum logic [1:0] {
        KIND_NONE  = 2'd0,
        KIND_START = 2'd1,
        KIND_WRITE = 2'd2,
        KIND_STOP  = 2'd3
    } kind_t;

    localparam logic [7:0]  MSB_MASK       = 8'h80;
    localparam logic [3:0]  BITS_PER_BYTE  = 4'd8;
    localparam logic [2:0]  UNITS_COND     = 3'd5;  // start/stop hold
    localparam logic [2:0]  UNITS_RISE     = 3'd1;  // after SCL release
    localparam logic [2:0]  UNITS_PRE_SAMP = 3'd3;  // before SDA sample
    localparam logic [2:0]  UNITS_POST_SAMP = 3'd2; // before SCL low
    localparam logic [15:0] TICKS_RESET    = 16'd1;

endpackage

// ----- rtl/core/i2c_master_byte_writer.sv -----
// Top level: I2C master line sequencer, one tick per input transaction.
`timescale 1ns / 1ps

//  Channel  | Signals                                         | Direction | Handshake
//  ---------+-------------------------------------------------+-----------+----------------
//  input    | kind, data_byte, scl_level, sda_level           | in        | in_valid/ready
//  output   | scl_drive, sda_drive, busy_res, done_res,       | out       | out_valid/ready
//           | ack_bit                                         |           |
//  config   | cfg_write_data (ticks_per_delay)                | in        | cfg_write_en
//
//  Each input transaction is one tick of the line sequencer and yields exactly one
//  result transaction; one tick per cycle is sustained while the output is not stalled.
//  The sequencer state and the result register are both updated at the accepting
//  edge; the only thing between them is the next-state logic of this tick.
//  Reset (rst_n, asynchronous, active low) puts the sequencer idle, both lines
//  released, ack high and ticks_per_delay at 1.
//  A stalled output holds its result; input is taken whenever the result register
//  is empty or is being emptied in the same cycle.

module i2c_master_byte_writer
(
    input  logic        clk,
    input  logic        rst_n,

    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  kind,
    input  logic [7:0]  data_byte,
    input  logic        scl_level,
    input  logic        sda_level,

    output logic        out_valid,
    input  logic        out_ready,
    output logic        scl_drive,
    output logic        sda_drive,
    output logic        busy_res,
    output logic        done_res,
    output logic        ack_bit,

    input  logic        cfg_write_en,
    input  logic [15:0] cfg_write_data
);

    // ---------------------------------------------------------------------
    // Sequencer state
    // ---------------------------------------------------------------------
    i2cmbw_pkg::phase_t phase_reg, phase_next;
    logic [7:0]  shift_reg, shift_next;
    logic [3:0]  bit_count_reg, bit_count_next;
    logic [15:0] tick_count_reg, tick_count_next;
    logic [2:0]  units_left_reg, units_left_next;
    logic        scl_out_reg, scl_out_next;
    logic        sda_out_reg, sda_out_next;
    logic        ack_reg, ack_next;
    logic        done_next;

    logic [15:0] ticks_per_delay_reg;

    // result register
    logic        out_valid_reg, out_valid_next;
    logic        res_scl_reg, res_sda_reg, res_busy_reg, res_done_reg, res_ack_reg;

    logic        in_accept;

    // Unit timer: one tick further, and whether a unit (and the last unit) ends.
    // A zero tick count behaves as one, since the compare always passes.
    logic [15:0] tick_inc;
    logic        unit_end;
    logic [2:0]  units_dec;
    logic        units_done;

    assign in_ready  = !out_valid_reg || out_ready;
    assign in_accept = in_valid && in_ready;

    assign tick_inc   = tick_count_reg + 16'd1;
    assign unit_end   = (tick_inc >= ticks_per_delay_reg);
    assign units_dec  = units_left_reg - 3'd1;
    assign units_done = unit_end && (units_dec == 3'd0);

    // ---------------------------------------------------------------------
    // Next-state logic for one tick
    // ---------------------------------------------------------------------
    always_comb
    begin
        phase_next      = phase_reg;
        shift_next      = shift_reg;
        bit_count_next  = bit_count_reg;
        tick_count_next = tick_count_reg;
        units_left_next = units_left_reg;
        scl_out_next    = scl_out_reg;
        sda_out_next    = sda_out_reg;
        ack_next        = ack_reg;
        done_next       = 1'b0;

        case (phase_reg)
            i2cmbw_pkg::PH_IDLE:
            begin
                // commands only count while idle
                case (i2cmbw_pkg::kind_t'(kind))
                    i2cmbw_pkg::KIND_START:
                    begin
                        scl_out_next = 1'b1;
                        sda_out_next = 1'b1;
                        phase_next   = i2cmbw_pkg::PH_START_FALL;
                    end
                    i2cmbw_pkg::KIND_WRITE:
                    begin
                        shift_next     = data_byte;
                        bit_count_next = 4'd0;
                        sda_out_next   = |(data_byte & i2cmbw_pkg::MSB_MASK);
                        phase_next     = i2cmbw_pkg::PH_CLK_RISE;
                    end
                    i2cmbw_pkg::KIND_STOP:
                    begin
                        sda_out_next = 1'b0;
                        phase_next   = i2cmbw_pkg::PH_STOP_RISE;
                    end
                    default:
                    begin
                        phase_next = i2cmbw_pkg::PH_IDLE;
                    end
                endcase
            end

            i2cmbw_pkg::PH_START_FALL:
            begin
                sda_out_next    = 1'b0;
                units_left_next = i2cmbw_pkg::UNITS_COND;
                tick_count_next = 16'd0;
                phase_next      = i2cmbw_pkg::PH_START_WAIT;
            end

            i2cmbw_pkg::PH_START_WAIT,
            i2cmbw_pkg::PH_STOP_WAIT,
            i2cmbw_pkg::PH_CLK_UNIT1,
            i2cmbw_pkg::PH_CLK_WAIT3,
            i2cmbw_pkg::PH_CLK_WAIT2:
            begin
                tick_count_next = unit_end ? 16'd0 : tick_inc;
                if (unit_end)
                begin
                    units_left_next = units_dec;
                end
                if (units_done)
                begin
                    case (phase_reg)
                        i2cmbw_pkg::PH_START_WAIT:
                        begin
                            scl_out_next = 1'b0;
                            done_next    = 1'b1;
                            phase_next   = i2cmbw_pkg::PH_IDLE;
                        end
                        i2cmbw_pkg::PH_STOP_WAIT:
                        begin
                            sda_out_next = 1'b1;
                            done_next    = 1'b1;
                            phase_next   = i2cmbw_pkg::PH_IDLE;
                        end
                        i2cmbw_pkg::PH_CLK_UNIT1:
                        begin
                            phase_next = i2cmbw_pkg::PH_CLK_STRETCH;
                        end
                        i2cmbw_pkg::PH_CLK_WAIT3:
                        begin
                            // ninth clock: sample the ack
                            if (bit_count_reg >= i2cmbw_pkg::BITS_PER_BYTE)
                            begin
                                ack_next = sda_level;
                            end
                            units_left_next = i2cmbw_pkg::UNITS_POST_SAMP;
                            tick_count_next = 16'd0;
                            phase_next      = i2cmbw_pkg::PH_CLK_WAIT2;
                        end
                        default:
                        begin
                            // end of high time
                            scl_out_next = 1'b0;
                            if (bit_count_reg >= i2cmbw_pkg::BITS_PER_BYTE)
                            begin
                                done_next  = 1'b1;
                                phase_next = i2cmbw_pkg::PH_IDLE;
                            end
                            else
                            begin
                                phase_next = i2cmbw_pkg::PH_BIT_NEXT;
                            end
                        end
                    endcase
                end
            end

            i2cmbw_pkg::PH_STOP_RISE:
            begin
                scl_out_next    = 1'b1;
                units_left_next = i2cmbw_pkg::UNITS_COND;
                tick_count_next = 16'd0;
                phase_next      = i2cmbw_pkg::PH_STOP_WAIT;
            end

            i2cmbw_pkg::PH_CLK_RISE:
            begin
                scl_out_next    = 1'b1;
                units_left_next = i2cmbw_pkg::UNITS_RISE;
                tick_count_next = 16'd0;
                phase_next      = i2cmbw_pkg::PH_CLK_UNIT1;
            end

            i2cmbw_pkg::PH_CLK_STRETCH:
            begin
                // slave may hold SCL low
                if (scl_level)
                begin
                    units_left_next = i2cmbw_pkg::UNITS_PRE_SAMP;
                    tick_count_next = 16'd0;
                    phase_next      = i2cmbw_pkg::PH_CLK_WAIT3;
                end
            end

            i2cmbw_pkg::PH_BIT_NEXT:
            begin
                bit_count_next = bit_count_reg + 4'd1;
                shift_next     = {shift_reg[6:0], 1'b0};
                // release SDA for the ack clock
                if (bit_count_next >= i2cmbw_pkg::BITS_PER_BYTE)
                begin
                    sda_out_next = 1'b1;
                end
                else
                begin
                    sda_out_next = |(shift_next & i2cmbw_pkg::MSB_MASK);
                end
                phase_next = i2cmbw_pkg::PH_CLK_RISE;
            end

            default:
            begin
                phase_next = i2cmbw_pkg::PH_IDLE;
            end
        endcase
    end

    assign out_valid_next = in_accept || (out_valid_reg && !out_ready);

    // ---------------------------------------------------------------------
    // Control registers
    // ---------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg           <= i2cmbw_pkg::PH_IDLE;
            shift_reg           <= 8'd0;
            bit_count_reg       <= 4'd0;
            tick_count_reg      <= 16'd0;
            units_left_reg      <= 3'd0;
            scl_out_reg         <= 1'b1;
            sda_out_reg         <= 1'b1;
            ack_reg             <= 1'b1;
            ticks_per_delay_reg <= i2cmbw_pkg::TICKS_RESET;
            out_valid_reg       <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (cfg_write_en)
            begin
                ticks_per_delay_reg <= cfg_write_data;
            end
            if (in_accept)
            begin
                phase_reg      <= phase_next;
                shift_reg      <= shift_next;
                bit_count_reg  <= bit_count_next;
                tick_count_reg <= tick_count_next;
                units_left_reg <= units_left_next;
                scl_out_reg    <= scl_out_next;
                sda_out_reg    <= sda_out_next;
                ack_reg        <= ack_next;
            end
        end
    end

    // result payload, no reset needed
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            res_scl_reg  <= scl_out_next;
            res_sda_reg  <= sda_out_next;
            res_busy_reg <= (phase_next != i2cmbw_pkg::PH_IDLE);
            res_done_reg <= done_next;
            res_ack_reg  <= ack_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign scl_drive = res_scl_reg;
    assign sda_drive = res_sda_reg;
    assign busy_res  = res_busy_reg;
    assign done_res  = res_done_reg;
    assign ack_bit   = res_ack_reg;

    // ---------------------------------------------------------------------
    // Assertions
    // ---------------------------------------------------------------------
    a_done_not_busy: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !(done_res && busy_res))
        else $error("done and busy reported together");

    a_busy_tracks_phase: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (busy_res == (phase_reg != i2cmbw_pkg::PH_IDLE)))
        else $error("busy result disagrees with sequencer phase");

    a_empty_takes_input: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
        else $error("input stalled with an empty result register");

    a_start_releases: assert property (@(posedge clk) disable iff (!rst_n)
        (in_accept && phase_reg == i2cmbw_pkg::PH_IDLE && kind == i2cmbw_pkg::KIND_START)
        |=> (scl_drive && sda_drive && busy_res))
        else $error("start command did not release both lines");

endmodule
